FILE: hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the convolution core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cnv2d_pkg.sv
// ============================================================================
// cnv2d_pkg
// Types and fixed constants shared by the circular 2D convolution core.
// ============================================================================
package cnv2d_pkg;

  localparam int POS_W      = 6;
  localparam int DIM_W      = 7;
  localparam int ANCHOR_W   = 2;
  localparam int PIX_IN_W   = 16;
  localparam int PIX_EXT_W  = 24;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 48;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int QUEUE_DEPTH = 2;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd6;

  // One queued command. For a store, x and y are the raw position and
  // wr_en says it lies inside the store. For a compute, x and y are the
  // wrapped top-left corner of the kernel window.
  typedef struct packed {
    logic                op;
    logic                wr_en;
    logic [DIM_W-1:0]    x;
    logic [DIM_W-1:0]    y;
    logic [PIX_IN_W-1:0] pixel;
  } cmd_t;

  // Effective (clamped) geometry and anchor.
  typedef struct packed {
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [ANCHOR_W-1:0] ax;
    logic [ANCHOR_W-1:0] ay;
  } dims_t;

  // Kernel rows, row 0 at index 0; column 0 in the low 16 bits of a row.
  typedef logic [2:0][ROW_W-1:0] kernel_t;

endpackage

FILE: hw/rtl/circular_2d_convolution_core.sv
// ============================================================================
// circular_2d_convolution_core
// 3x3 convolution with circular wraparound over a frame of signed pixels.
// ============================================================================
// Use: the input channel (in_valid/in_ready) carries store and compute items.
// A store writes in_pixel_in at (in_pos_x, in_pos_y) and yields no result;
// a compute yields one transfer on the result channel (out_valid/out_ready)
// with the Q4.12 window sum, floor-shifted and clipped to 24 bits, and a flag
// telling whether it was clipped. Registers are written through cfg_valid,
// cfg_index and cfg_wdata; the user must write them only while the block
// is idle, as the block itself does not enforce this. A compute reduces its
// position modulo the image size, passes through the queue, then in the back
// end reads the frame memory once per tap through the single memory port and
// passes two pipeline stages and the result load; a store skips the
// reduction. The front end takes no new item until it has pushed the last;
// the back end pops none while a compute runs, up to its result load.
// Reset clears the control state and restores the register defaults; the
// frame memory keeps no reset and must be written before it is read.
// When the receiver stalls, the result register holds its transfer, the back
// end waits, and the two-entry queue and the front end keep taking items
// until they fill.
// ============================================================================
`include "assert_macros.svh"

module circular_2d_convolution_core #(
  parameter int MAX_WIDTH      = 64,
  parameter int MAX_HEIGHT     = 64,
  parameter int KERNEL_SIZE    = 3,
  parameter int PIXEL_BITS     = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic [cnv2d_pkg::POS_W-1:0]           in_pos_x,
  input  logic [cnv2d_pkg::POS_W-1:0]           in_pos_y,
  input  logic signed [cnv2d_pkg::PIX_IN_W-1:0] in_pixel_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cnv2d_pkg::OUT_W-1:0]    out_filtered,
  output logic                                  out_saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cnv2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cnv2d_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int DW = cnv2d_pkg::DIM_W;
  localparam int AWD = cnv2d_pkg::ANCHOR_W;

  // Configuration registers keep the bits as written; the geometry used
  // by the datapath is clamped below.
  logic [DW-1:0]  image_width_r, image_height_r;
  logic [AWD-1:0] anchor_x_r, anchor_y_r;
  cnv2d_pkg::kernel_t kernel_r;

  cnv2d_pkg::dims_t dims;
  cnv2d_pkg::cmd_t  q_in, q_out;
  logic             q_push, q_pop, q_full, q_empty;

  // The block takes a register write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DW'(64);
      image_height_r <= DW'(64);
      anchor_x_r     <= AWD'(1);
      anchor_y_r     <= AWD'(1);
      kernel_r[0]    <= '0;
      kernel_r[1]    <= cnv2d_pkg::ROW_W'(48'h0000_1000_0000);
      kernel_r[2]    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cnv2d_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[DW-1:0];
        cnv2d_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[DW-1:0];
        cnv2d_pkg::REG_ANCHOR_X:     anchor_x_r     <= cfg_wdata[AWD-1:0];
        cnv2d_pkg::REG_ANCHOR_Y:     anchor_y_r     <= cfg_wdata[AWD-1:0];
        cnv2d_pkg::REG_KERNEL_TOP:   kernel_r[0]    <= cfg_wdata;
        cnv2d_pkg::REG_KERNEL_MID:   kernel_r[1]    <= cfg_wdata;
        cnv2d_pkg::REG_KERNEL_BOT:   kernel_r[2]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Active size is clamped to 1..MAX; a zero width or height acts as one.
  always_comb begin
    if (image_width_r == '0) begin
      dims.w = DW'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      dims.w = DW'(MAX_WIDTH);
    end else begin
      dims.w = image_width_r;
    end
    if (image_height_r == '0) begin
      dims.h = DW'(1);
    end else if (int'(image_height_r) > MAX_HEIGHT) begin
      dims.h = DW'(MAX_HEIGHT);
    end else begin
      dims.h = image_height_r;
    end
    dims.ax = anchor_x_r;
    dims.ay = anchor_y_r;
  end

  // Front end: takes items, works out the wrapped window corner.
  cnv2d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pixel_in (in_pixel_in),
    .dims        (dims),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_full      (q_full)
  );

  // Decouples the front end from the memory-bound back end.
  cnv2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back end: frame memory, window scan, MAC and the result register.
  cnv2d_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .KERNEL_SIZE    (KERNEL_SIZE),
    .PIXEL_BITS     (PIXEL_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .dim_w         (dims.w),
    .dim_h         (dims.h),
    .kernel        (kernel_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_filtered  (out_filtered),
    .out_saturated (out_saturated)
  );

  // The front end never pushes into a full queue.
  `ASSERT_ALWAYS(a_no_push_full, clk, rst_n, !(q_push && q_full), "push into full queue")
  // The back end never pops an empty queue.
  `ASSERT_ALWAYS(a_no_pop_empty, clk, rst_n, !(q_pop && q_empty), "pop from empty queue")
  // A clipped result sits at one of the two range limits.
  `ASSERT_IMPLIES(a_sat_at_limit, clk, rst_n, out_valid && out_saturated,
    out_filtered == 24'sh7FFFFF || out_filtered == -24'sh800000, "clipped result off limit")

endmodule

FILE: hw/rtl/cnv2d_front.sv
// ============================================================================
// cnv2d_front
// Accepts input items, reduces compute positions modulo the image size and
// queues a command for the back end.
// ============================================================================
module cnv2d_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [cnv2d_pkg::POS_W-1:0]       in_pos_x,
  input  logic [cnv2d_pkg::POS_W-1:0]       in_pos_y,
  input  logic signed [cnv2d_pkg::PIX_IN_W-1:0] in_pixel_in,
  input  cnv2d_pkg::dims_t                  dims,
  output logic                              q_push,
  output cnv2d_pkg::cmd_t                   q_data,
  input  logic                              q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam int DW = cnv2d_pkg::DIM_W;
  localparam int PW = cnv2d_pkg::POS_W;
  localparam logic [2:0] CNT_LAST = 3'(PW - 1);

  logic [1:0]    state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [PW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [cnv2d_pkg::PIX_IN_W-1:0] pix_r, pix_nxt;
  logic [DW-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [DW:0]   tx, ty;

  // Step a wrapped coordinate back by the anchor, one position at a time.
  function automatic logic [DW-1:0] back_off(input logic [DW-1:0] c,
                                             input logic [DW-1:0] d,
                                             input logic [cnv2d_pkg::ANCHOR_W-1:0] a);
    logic [DW-1:0] v;
    v = c;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(a)) begin
        v = (v == '0) ? DW'(d - 1'b1) : DW'(v - 1'b1);
      end
    end
    return v;
  endfunction

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;

  always_comb begin
    q_data.op    = op_r;
    q_data.pixel = pix_r;
    if (op_r == cnv2d_pkg::OP_COMPUTE) begin
      q_data.wr_en = 1'b0;
      q_data.x     = back_off(rx_r, dims.w, dims.ax);
      q_data.y     = back_off(ry_r, dims.h, dims.ay);
    end else begin
      q_data.wr_en = (int'(px_r) < MAX_WIDTH) && (int'(py_r) < MAX_HEIGHT);
      q_data.x     = {1'b0, px_r};
      q_data.y     = {1'b0, py_r};
    end
  end

  // Restoring remainder, one position bit per cycle, x and y side by side.
  assign tx = {rx_r, px_r[PW-1]};
  assign ty = {ry_r, py_r[PW-1]};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pix_nxt   = pix_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          pix_nxt   = in_pixel_in;
          rx_nxt    = '0;
          ry_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = (in_op == cnv2d_pkg::OP_COMPUTE) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        rx_nxt  = (tx >= {1'b0, dims.w}) ? DW'(tx - {1'b0, dims.w}) : tx[DW-1:0];
        ry_nxt  = (ty >= {1'b0, dims.h}) ? DW'(ty - {1'b0, dims.h}) : ty[DW-1:0];
        px_nxt  = px_r << 1;
        py_nxt  = py_r << 1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pix_r <= pix_nxt;
    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

FILE: hw/rtl/cnv2d_queue.sv
// ============================================================================
// cnv2d_queue
// Short command queue between the front end and the back end.
// ============================================================================
module cnv2d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cnv2d_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output cnv2d_pkg::cmd_t pop_data,
  output logic            empty
);

  localparam int D  = cnv2d_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(D - 1);

  cnv2d_pkg::cmd_t ent_r [D];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(D));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/cnv2d_back.sv
// ============================================================================
// cnv2d_back
// Frame memory, window scan, multiply-accumulate and result register.
// ============================================================================
module cnv2d_back #(
  parameter int MAX_WIDTH      = 64,
  parameter int MAX_HEIGHT     = 64,
  parameter int KERNEL_SIZE    = 3,
  parameter int PIXEL_BITS     = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  cnv2d_pkg::cmd_t                     q_data,
  input  logic [cnv2d_pkg::DIM_W-1:0]         dim_w,
  input  logic [cnv2d_pkg::DIM_W-1:0]         dim_h,
  input  cnv2d_pkg::kernel_t                  kernel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cnv2d_pkg::OUT_W-1:0]  out_filtered,
  output logic                                out_saturated
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_WAIT = 2'd2;

  localparam int DW     = cnv2d_pkg::DIM_W;
  localparam int CWID   = cnv2d_pkg::COEF_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = PIXEL_BITS + CWID;
  localparam int ACC_W  = PROD_W + 4;
  localparam logic [1:0] K_LAST = 2'(KERNEL_SIZE - 1);
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(cnv2d_pkg::OUT_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(cnv2d_pkg::OUT_MIN);

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    u_r, u_nxt, v_r, v_nxt;
  logic [DW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, x0_r, x0_nxt;

  logic                         rd_vld_r, rd_last_r;
  logic signed [CWID-1:0]       rd_coef_r;
  logic signed [PIXEL_BITS-1:0] mem_rdata_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         prod_vld_r, prod_last_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic                         done_r;
  logic                         out_valid_r, sat_r;
  logic signed [cnv2d_pkg::OUT_W-1:0] filtered_r;

  logic                   start, mem_we, issue, tap_last, out_load;
  logic [AW-1:0]          mem_addr;
  logic [PIXEL_BITS-1:0]  mem_wdata;
  logic [cnv2d_pkg::ROW_W-1:0] row;
  logic signed [CWID-1:0] coef;
  logic signed [ACC_W-1:0] q;
  logic                   sat_hi, sat_lo;

  function automatic logic [DW-1:0] wrap_inc(input logic [DW-1:0] c,
                                             input logic [DW-1:0] d);
    return (c == DW'(d - 1'b1)) ? '0 : DW'(c + 1'b1);
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [DW-1:0] x,
                                             input logic [DW-1:0] y);
    return AW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign start    = q_pop && (q_data.op == cnv2d_pkg::OP_COMPUTE);
  assign mem_we   = q_pop && (q_data.op == cnv2d_pkg::OP_STORE) && q_data.wr_en;
  assign issue    = (state_r == B_READ);
  assign tap_last = (u_r == K_LAST) && (v_r == K_LAST);
  assign mem_addr = issue ? pix_addr(cx_r, cy_r) : pix_addr(q_data.x, q_data.y);
  assign mem_wdata = PIXEL_BITS'({{(cnv2d_pkg::PIX_EXT_W - cnv2d_pkg::PIX_IN_W)
                                   {q_data.pixel[cnv2d_pkg::PIX_IN_W-1]}}, q_data.pixel});
  assign out_load = (state_r == B_WAIT) && done_r && (!out_valid_r || out_ready);

  always_comb begin
    case (v_r)
      2'd0:    row = kernel[0];
      2'd1:    row = kernel[1];
      default: row = kernel[2];
    endcase
    case (u_r)
      2'd0:    coef = row[CWID-1:0];
      2'd1:    coef = row[2*CWID-1:CWID];
      default: coef = row[3*CWID-1:2*CWID];
    endcase
  end

  // Floor shift, then clip to the 24-bit result range.
  assign q      = acc_r >>> COEF_FRAC_BITS;
  assign sat_hi = (q > Q_MAX);
  assign sat_lo = (q < Q_MIN);

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    x0_nxt    = x0_r;
    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          u_nxt     = '0;
          v_nxt     = '0;
          cx_nxt    = q_data.x;
          x0_nxt    = q_data.x;
          cy_nxt    = q_data.y;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        if (u_r == K_LAST) begin
          u_nxt  = '0;
          cx_nxt = x0_r;
          v_nxt  = 2'(v_r + 1'b1);
          cy_nxt = wrap_inc(cy_r, dim_h);
        end else begin
          u_nxt  = 2'(u_r + 1'b1);
          cx_nxt = wrap_inc(cx_r, dim_w);
        end
        if (tap_last) begin
          state_nxt = B_WAIT;
        end
      end
      B_WAIT: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= issue;
      prod_vld_r <= rd_vld_r;
      if (start) begin
        done_r <= 1'b0;
      end else if (prod_vld_r && prod_last_r) begin
        done_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    x0_r        <= x0_nxt;
    rd_coef_r   <= coef;
    rd_last_r   <= tap_last;
    prod_r      <= mem_rdata_r * rd_coef_r;
    prod_last_r <= rd_last_r;
    if (start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (out_load) begin
      sat_r      <= sat_hi || sat_lo;
      filtered_r <= sat_hi ? cnv2d_pkg::OUT_W'(cnv2d_pkg::OUT_MAX) :
                    sat_lo ? cnv2d_pkg::OUT_W'(cnv2d_pkg::OUT_MIN) :
                             q[cnv2d_pkg::OUT_W-1:0];
    end
  end

  // Single-port frame memory: stores write, the window scan reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = filtered_r;
  assign out_saturated = sat_r;

endmodule

FILE: bench/circular_2d_convolution_core_tb.sv
// ============================================================================
// circular_2d_convolution_core_tb
// Self-checking bench for the circular 3x3 convolution core.
// ============================================================================
// A short table of store and compute items runs first on the reset registers,
// with the expected results typed in. After that, a series of register
// settings follows, each with a random mix of stores and computes. Every
// compute there is scored against a cycle-free model of the frame and the window
// sum kept inside this bench. Both channels idle in random bursts, and at one
// point the result side holds off long enough for the core to back up.
// ============================================================================
module circular_2d_convolution_core_tb;

  localparam int FRAME_W         = 64;
  localparam int FRAME_H         = 64;
  localparam int FRAC_BITS       = 12;
  localparam int DIRECTED_ROWS   = 20;
  localparam int NUM_SETTINGS    = 8;
  localparam int ITEMS_PER_SET   = 240;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;

  // One expected result of a compute.
  typedef struct {
    logic signed [cnv2d_pkg::OUT_W-1:0] filtered;
    logic                               saturated;
  } conv_result_t;

  // One register setting, written as a whole between phases.
  typedef struct {
    logic [cnv2d_pkg::DIM_W-1:0]    width;
    logic [cnv2d_pkg::DIM_W-1:0]    height;
    logic [cnv2d_pkg::ANCHOR_W-1:0] anchor_x;
    logic [cnv2d_pkg::ANCHOR_W-1:0] anchor_y;
    logic [cnv2d_pkg::ROW_W-1:0]    rows [3];
  } conv_setting_t;

  // One row of the directed table. Only computes carry a typed-in result.
  typedef struct packed {
    logic                           op;
    logic [cnv2d_pkg::POS_W-1:0]    x;
    logic [cnv2d_pkg::POS_W-1:0]    y;
    logic [cnv2d_pkg::PIX_IN_W-1:0] pixel;
    logic                           typed;
    logic [cnv2d_pkg::OUT_W-1:0]    want;
  } stim_row_t;

  // The reset kernel is the identity (1.0 at the center tap, anchors 1,1), so
  // a compute here returns the pixel under the output position. The stores
  // cover the wrapped 3x3 neighborhoods of the corners that get computed.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{cnv2d_pkg::OP_STORE,   6'd63, 6'd63, 16'h0001, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd0,  6'd63, 16'hFFFF, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd1,  6'd63, 16'h0002, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd63, 6'd0,  16'h0064, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd0,  6'd0,  16'h8000, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd1,  6'd0,  16'hFFFE, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd63, 6'd1,  16'h0003, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd0,  6'd1,  16'hFFFD, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd1,  6'd1,  16'h0004, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_COMPUTE, 6'd0,  6'd0,  16'hFFFF, 1'b1, 24'hFF8000},
    '{cnv2d_pkg::OP_STORE,   6'd0,  6'd0,  16'h7FFF, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_COMPUTE, 6'd0,  6'd0,  16'h0000, 1'b1, 24'h007FFF},
    '{cnv2d_pkg::OP_STORE,   6'd62, 6'd62, 16'h0005, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd63, 6'd62, 16'h0006, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd0,  6'd62, 16'h0007, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd62, 6'd63, 16'h0008, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_STORE,   6'd62, 6'd0,  16'h0009, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_COMPUTE, 6'd63, 6'd63, 16'h8000, 1'b1, 24'h000001},
    '{cnv2d_pkg::OP_STORE,   6'd62, 6'd1,  16'h8000, 1'b0, 24'h000000},
    '{cnv2d_pkg::OP_COMPUTE, 6'd63, 6'd0,  16'h7FFF, 1'b1, 24'h000064}
  };

  // Every input of the core starts at a known value.
  logic                                  clk           = 1'b0;
  logic                                  rst_n         = 1'b0;
  logic                                  in_valid      = 1'b0;
  logic                                  in_ready;
  logic                                  in_op         = cnv2d_pkg::OP_STORE;
  logic [cnv2d_pkg::POS_W-1:0]           in_pos_x      = '0;
  logic [cnv2d_pkg::POS_W-1:0]           in_pos_y      = '0;
  logic signed [cnv2d_pkg::PIX_IN_W-1:0] in_pixel_in   = '0;
  logic                                  out_valid;
  logic                                  out_ready     = 1'b0;
  logic signed [cnv2d_pkg::OUT_W-1:0]    out_filtered;
  logic                                  out_saturated;
  logic                                  cfg_valid     = 1'b0;
  logic                                  cfg_ready;
  logic [cnv2d_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
  logic [cnv2d_pkg::CFG_DATA_W-1:0]      cfg_wdata     = '0;

  // Shadow of the frame and of the registers, updated at each transfer.
  logic signed [cnv2d_pkg::PIX_IN_W-1:0] frame_pix [FRAME_W*FRAME_H];
  bit                                    frame_written [FRAME_W*FRAME_H];
  logic [cnv2d_pkg::DIM_W-1:0]           width_reg;
  logic [cnv2d_pkg::DIM_W-1:0]           height_reg;
  logic [cnv2d_pkg::ANCHOR_W-1:0]        anchor_x_reg;
  logic [cnv2d_pkg::ANCHOR_W-1:0]        anchor_y_reg;
  logic [cnv2d_pkg::ROW_W-1:0]           kernel_reg [3];

  conv_result_t expected_q [$];

  int  error_count   = 0;
  int  cycle_count   = 0;
  int  item_count    = 0;
  int  store_count   = 0;
  int  compute_count = 0;
  int  setting_count = 0;
  bit  src_idles     = 1'b1;
  bit  sink_idles    = 1'b1;
  bit  hold_off_req  = 1'b0;

  circular_2d_convolution_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_filtered  (out_filtered),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window-sum model
  // --------------------------------------------------------------------------

  // The size registers keep any 7-bit value; the core works with the value
  // clamped into 1..64.
  function automatic int clamp_dim(input logic [cnv2d_pkg::DIM_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Frame address of kernel tap (col, row) for output position (x, y). The
  // 4*size bias keeps the sum positive for any anchor up to 3 before the
  // wrap, so positions beyond the active size also act as themselves mod size.
  function automatic int tap_addr(input logic [cnv2d_pkg::POS_W-1:0] x,
                                  input logic [cnv2d_pkg::POS_W-1:0] y,
                                  input int col, input int row);
    int w;
    int h;
    int nx;
    int ny;
    w  = clamp_dim(width_reg, FRAME_W);
    h  = clamp_dim(height_reg, FRAME_H);
    nx = (int'(x) + col + 4 * w - int'(anchor_x_reg)) % w;
    ny = (int'(y) + row + 4 * h - int'(anchor_y_reg)) % h;
    return ny * FRAME_W + nx;
  endfunction

  // Correlation over the 3x3 window (the kernel is not flipped), Q4.12 sum
  // floor-shifted by an arithmetic shift and then clipped to 24 bits. With
  // 16-bit pixels the clip cannot actually be reached, but it is modeled.
  function automatic conv_result_t predict_conv(input logic [cnv2d_pkg::POS_W-1:0] x,
                                                input logic [cnv2d_pkg::POS_W-1:0] y);
    conv_result_t                        res;
    logic signed [63:0]                  acc;
    logic signed [63:0]                  q;
    logic signed [cnv2d_pkg::COEF_W-1:0] coef;
    acc = '0;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        coef = kernel_reg[row][cnv2d_pkg::COEF_W*col +: cnv2d_pkg::COEF_W];
        acc  = acc + coef * frame_pix[tap_addr(x, y, col, row)];
      end
    end
    q = acc >>> FRAC_BITS;
    res.saturated = 1'b0;
    if (q > cnv2d_pkg::OUT_MAX) begin
      q = 64'(cnv2d_pkg::OUT_MAX);
      res.saturated = 1'b1;
    end else if (q < cnv2d_pkg::OUT_MIN) begin
      q = 64'(cnv2d_pkg::OUT_MIN);
      res.saturated = 1'b1;
    end
    res.filtered = q[cnv2d_pkg::OUT_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [cnv2d_pkg::PIX_IN_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [cnv2d_pkg::ROW_W-1:0] rand_kernel_row();
    logic [cnv2d_pkg::ROW_W-1:0] r;
    for (int col = 0; col < 3; col++) begin
      case ($urandom_range(0, 5))
        0:       r[cnv2d_pkg::COEF_W*col +: cnv2d_pkg::COEF_W] = 16'h7FFF;
        1:       r[cnv2d_pkg::COEF_W*col +: cnv2d_pkg::COEF_W] = 16'h8000;
        2:       r[cnv2d_pkg::COEF_W*col +: cnv2d_pkg::COEF_W] = 16'h0000;
        3:       r[cnv2d_pkg::COEF_W*col +: cnv2d_pkg::COEF_W] = 16'h1000;
        default: r[cnv2d_pkg::COEF_W*col +: cnv2d_pkg::COEF_W] = 16'($urandom);
      endcase
    end
    return r;
  endfunction

  // Offers one item and waits for its transfer. Valid is left high so that
  // the next call can follow on the very next cycle; an idle burst lowers it
  // first. The shadow frame is updated, or the expectation queued, at the
  // transfer edge, so results can never run ahead of their expectation.
  task automatic send_item(input logic op,
                           input logic [cnv2d_pkg::POS_W-1:0] x,
                           input logic [cnv2d_pkg::POS_W-1:0] y,
                           input logic [cnv2d_pkg::PIX_IN_W-1:0] pixel,
                           input logic typed,
                           input logic [cnv2d_pkg::OUT_W-1:0] want);
    conv_result_t res;
    if (src_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_pos_x    <= x;
    in_pos_y    <= y;
    in_pixel_in <= pixel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == cnv2d_pkg::OP_STORE) begin
      frame_pix[{y, x}]     = pixel;
      frame_written[{y, x}] = 1'b1;
      store_count++;
    end else begin
      if (typed) begin
        res.filtered  = want;
        res.saturated = 1'b0;
      end else begin
        res = predict_conv(x, y);
      end
      expected_q.push_back(res);
      compute_count++;
    end
    item_count++;
  endtask

  // A compute preceded by stores to any window pixel that was never written,
  // so that every frame read of the core hits defined data.
  task automatic issue_compute(input logic [cnv2d_pkg::POS_W-1:0] x,
                               input logic [cnv2d_pkg::POS_W-1:0] y);
    int addr;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        addr = tap_addr(x, y, col, row);
        if (!frame_written[addr])
          send_item(cnv2d_pkg::OP_STORE, addr[5:0], addr[11:6], rand_pixel(), 1'b0, '0);
      end
    end
    send_item(cnv2d_pkg::OP_COMPUTE, x, y, 16'($urandom), 1'b0, '0);
  endtask

  // Waits until every expected result has come back, then lets the core
  // finish any store still in flight before the registers may be touched.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all seven registers back to back over the configuration channel.
  task automatic apply_setting(input conv_setting_t s);
    logic [cnv2d_pkg::CFG_IDX_W-1:0]  idx  [7];
    logic [cnv2d_pkg::CFG_DATA_W-1:0] data [7];
    idx  = '{cnv2d_pkg::REG_IMAGE_WIDTH, cnv2d_pkg::REG_IMAGE_HEIGHT,
             cnv2d_pkg::REG_ANCHOR_X, cnv2d_pkg::REG_ANCHOR_Y,
             cnv2d_pkg::REG_KERNEL_TOP, cnv2d_pkg::REG_KERNEL_MID,
             cnv2d_pkg::REG_KERNEL_BOT};
    data = '{48'(s.width), 48'(s.height), 48'(s.anchor_x), 48'(s.anchor_y),
             s.rows[0], s.rows[1], s.rows[2]};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        cnv2d_pkg::REG_IMAGE_WIDTH:  width_reg     = data[i][cnv2d_pkg::DIM_W-1:0];
        cnv2d_pkg::REG_IMAGE_HEIGHT: height_reg    = data[i][cnv2d_pkg::DIM_W-1:0];
        cnv2d_pkg::REG_ANCHOR_X:     anchor_x_reg  = data[i][cnv2d_pkg::ANCHOR_W-1:0];
        cnv2d_pkg::REG_ANCHOR_Y:     anchor_y_reg  = data[i][cnv2d_pkg::ANCHOR_W-1:0];
        cnv2d_pkg::REG_KERNEL_TOP:   kernel_reg[0] = data[i];
        cnv2d_pkg::REG_KERNEL_MID:   kernel_reg[1] = data[i];
        cnv2d_pkg::REG_KERNEL_BOT:   kernel_reg[2] = data[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    conv_setting_t s;
    int            target;

    // Shadow registers start at the core's reset values.
    width_reg     = 7'd64;
    height_reg    = 7'd64;
    anchor_x_reg  = 2'd1;
    anchor_y_reg  = 2'd1;
    kernel_reg[0] = '0;
    kernel_reg[1] = 48'h0000_1000_0000;
    kernel_reg[2] = '0;
    for (int i = 0; i < FRAME_W * FRAME_H; i++) begin
      frame_pix[i]     = '0;
      frame_written[i] = 1'b0;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table on the reset registers.
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].pixel,
                DIRECTED[i].typed, DIRECTED[i].want);

    // Random phases, each under its own register setting. The first few hit
    // the extremes: a one-pixel image, sizes that clamp (0, 127 and 100), anchor 3,
    // and kernels of all-maximum or all-minimum coefficients.
    for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
      for (int row = 0; row < 3; row++) s.rows[row] = rand_kernel_row();
      s.width    = 7'($urandom_range(1, 64));
      s.height   = 7'($urandom_range(1, 64));
      s.anchor_x = 2'($urandom_range(0, 3));
      s.anchor_y = 2'($urandom_range(0, 3));
      case (phase)
        0: begin
          s.width    = 7'd64;
          s.height   = 7'd64;
          s.anchor_x = 2'd0;
          s.anchor_y = 2'd0;
        end
        1: begin
          s.width    = 7'd1;
          s.height   = 7'd1;
          s.anchor_x = 2'd2;
          s.anchor_y = 2'd2;
        end
        2: begin
          s.width    = 7'd0;
          s.height   = 7'd127;
          s.anchor_x = 2'd3;
          s.anchor_y = 2'd3;
        end
        3: begin
          s.width    = 7'd64;
          s.height   = 7'd1;
          s.anchor_x = 2'd0;
          s.anchor_y = 2'd3;
          for (int row = 0; row < 3; row++) s.rows[row] = {3{16'h7FFF}};
        end
        4: begin
          s.width    = 7'd1;
          s.height   = 7'd64;
          s.anchor_x = 2'd3;
          s.anchor_y = 2'd0;
          for (int row = 0; row < 3; row++) s.rows[row] = {3{16'h8000}};
        end
        5: s.width = 7'd100;
        default: ;
      endcase

      // The sender pauses here until every result is back.
      wait_idle();
      apply_setting(s);

      // Idling stays on except in the last phase, and maybe phase 6 for results;
      // the middle phase also starves results for a long stretch as items come in.
      src_idles  = (phase != NUM_SETTINGS - 1);
      sink_idles = (phase != NUM_SETTINGS - 1) && (phase != 6 || $urandom_range(0, 1));
      if (phase == 3) hold_off_req = 1'b1;

      // Mostly well-formed compute sequences; the rest are stray stores.
      target = item_count + ITEMS_PER_SET;
      while (item_count < target) begin
        if ($urandom_range(0, 9) < 6)
          issue_compute(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        else
          send_item(cnv2d_pkg::OP_STORE, 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)), rand_pixel(), 1'b0, '0);
      end
    end

    wait_idle();

    $display("Run covered %0d stores and %0d computes under reset values and %0d register",
             store_count, compute_count, setting_count);
    $display("settings (clamped sizes, anchor 3, extreme kernels, %0d-cycle output hold-off).",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("circular_2d_convolution_core test passed");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("circular_2d_convolution_core test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  always begin
    @(posedge clk);
    if (hold_off_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      hold_off_req = 1'b0;
      out_ready <= 1'b1;
    end else if (sink_idles && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result transfer is scored against the oldest expectation.
  always @(posedge clk) begin : score_result
    conv_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("Result with nothing expected: filtered %0d saturated %0b",
                   out_filtered, out_saturated);
      end else begin
        want = expected_q.pop_front();
        if (out_filtered !== want.filtered || out_saturated !== want.saturated) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("Mismatch: expected filtered %0d sat %0b, got filtered %0d sat %0b",
                     want.filtered, want.saturated, out_filtered, out_saturated);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_q.size());
      $display("circular_2d_convolution_core test failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cnv2d_pkg.sv
hw/rtl/cnv2d_front.sv
hw/rtl/cnv2d_queue.sv
hw/rtl/cnv2d_back.sv
hw/rtl/circular_2d_convolution_core.sv
bench/circular_2d_convolution_core_tb.sv
